### hdl/kl_pkg.sv
package kl_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    typedef enum logic [4:0] {
        KIND_IDENT   = 5'd0,
        KIND_IF      = 5'd1,
        KIND_FOR     = 5'd2,
        KIND_WHILE   = 5'd3,
        KIND_THAN    = 5'd4,
        KIND_INTEGER = 5'd5,
        KIND_PLUS    = 5'd6,
        KIND_MINUS   = 5'd7,
        KIND_SLASH   = 5'd8,
        KIND_STAR    = 5'd9,
        KIND_LPAREN  = 5'd10,
        KIND_RPAREN  = 5'd11,
        KIND_LBRACE  = 5'd12,
        KIND_RBRACE  = 5'd13,
        KIND_AMP     = 5'd14,
        KIND_SEMI    = 5'd15,
        KIND_EQUAL   = 5'd16,
        KIND_GREATER = 5'd17,
        KIND_LESS    = 5'd18,
        KIND_UNKNOWN = 5'd19,
        KIND_END     = 5'd20
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  tbyte;
        logic        is_last;
    } tok_t;

    typedef struct packed {
        logic [1:0] cnt;
        tok_t       tok0;
        tok_t       tok1;
    } push_t;

    localparam int FIFO_DEPTH = 4;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [3:0] KW_ALL = 4'hF;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_NEWLINE};
    endfunction

    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2F:   k = KIND_SLASH;
            8'h2A:   k = KIND_STAR;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h26:   k = KIND_AMP;
            8'h3B:   k = KIND_SEMI;
            8'h3D:   k = KIND_EQUAL;
            8'h3E:   k = KIND_GREATER;
            8'h3C:   k = KIND_LESS;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] kw_len(input logic [1:0] k);
        logic [15:0] n;
        case (k)
            2'd0:    n = 16'd2;
            2'd1:    n = 16'd3;
            2'd2:    n = 16'd5;
            default: n = 16'd4;
        endcase
        return n;
    endfunction

    // Character of keyword k at position idx, zero beyond its end.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [15:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            2'd0:
            begin
                case (idx)
                    16'd0:   ch = "i";
                    16'd1:   ch = "f";
                    default: ch = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (idx)
                    16'd0:   ch = "f";
                    16'd1:   ch = "o";
                    16'd2:   ch = "r";
                    default: ch = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (idx)
                    16'd0:   ch = "w";
                    16'd1:   ch = "h";
                    16'd2:   ch = "i";
                    16'd3:   ch = "l";
                    16'd4:   ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                case (idx)
                    16'd0:   ch = "t";
                    16'd1:   ch = "h";
                    16'd2:   ch = "a";
                    16'd3:   ch = "n";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] kw_narrow(input logic [3:0] alive, input logic [7:0] c,
                                             input logic [15:0] idx);
        logic [3:0] res;
        for (int k = 0; k < 4; k++)
        begin
            res[k] = alive[k] && (kw_char(2'(k), idx) == c);
        end
        return res;
    endfunction

    function automatic kind_t word_kind(input logic [3:0] alive, input logic [15:0] len);
        kind_t res;
        res = KIND_IDENT;
        if (alive[0] && len == kw_len(2'd0))
        begin
            res = KIND_IF;
        end
        else if (alive[1] && len == kw_len(2'd1))
        begin
            res = KIND_FOR;
        end
        else if (alive[2] && len == kw_len(2'd2))
        begin
            res = KIND_WHILE;
        end
        else if (alive[3] && len == kw_len(2'd3))
        begin
            res = KIND_THAN;
        end
        return res;
    endfunction

endpackage

### hdl/kl_token_fifo.sv
module kl_token_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  kl_pkg::push_t push,
    output logic          room,
    output logic          out_valid,
    input  logic          out_ready,
    output kl_pkg::tok_t  out_tok
);

    localparam int PTR_BITS = $clog2(kl_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(kl_pkg::FIFO_DEPTH + 1);

    kl_pkg::tok_t mem_reg [kl_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                pop;

    // Two entries must be free so that any word can be taken.
    assign room      = count_reg <= CNT_BITS'(kl_pkg::FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push.cnt) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_BITS'(1)] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/keyword_lexer.sv
// Byte-serial tokenizer: one text byte enters per word on the slave side, and tokens leave on
// the master side as soon as the byte that ends them has been seen. An input word is taken in
// every cycle while the four-entry token queue has two free entries. A word causes at most two
// tokens, and between any two two-token words lies at least one word that caused none, so the
// input side runs at one word per cycle for as long as the output side accepts a token in
// every cycle; it pauses only while the output side stalls and the queue fills. The scanner
// state and the keyword matcher update in the same cycle the byte is taken, and a token is
// written into the registered token queue when the word that completes it is taken.
module keyword_lexer
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tuser,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // token_kind, token_start, token_length, token_byte, zeros
    output logic        m_axis_tlast    // last_of_run
);

    kl_pkg::mode_t            mode_reg;
    kl_pkg::mode_t            mode_next;
    logic [15:0]              word_start_reg;
    logic [15:0]              word_start_next;
    logic [15:0]              word_length_reg;
    logic [15:0]              word_length_next;
    logic [POSITION_BITS-1:0] text_position_reg;
    logic [POSITION_BITS-1:0] text_position_next;
    logic [3:0]               keyword_alive_reg;
    logic [3:0]               keyword_alive_next;

    logic              accept;
    logic [7:0]        c;
    logic              eot;
    logic [15:0]       pos16;
    logic              pending;
    logic              cont;
    logic              has_a;
    logic              has_b;
    logic [15:0]       length_inc;
    kl_pkg::tok_t      tok_a;
    kl_pkg::tok_t      tok_b;
    kl_pkg::push_t     push;
    logic              room;
    kl_pkg::tok_t      out_tok;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = room;
    assign c     = s_axis_tdata;
    assign eot   = s_axis_tuser;
    assign pos16 = 16'(text_position_reg);

    assign pending = mode_reg inside {kl_pkg::MODE_WORD, kl_pkg::MODE_NUMBER};
    assign cont = !eot &&
        (((mode_reg == kl_pkg::MODE_WORD) && (kl_pkg::is_letter(c) || c == kl_pkg::CHAR_UNDERSCORE))
        || ((mode_reg == kl_pkg::MODE_NUMBER) && kl_pkg::is_digit(c)));
    assign length_inc = (word_length_reg == kl_pkg::LEN_MAX) ? word_length_reg
                                                             : word_length_reg + 16'd1;

    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            if (eot)
            begin
                mode_next = kl_pkg::MODE_IDLE;
            end
            else if (!cont)
            begin
                if (kl_pkg::is_letter(c))
                begin
                    mode_next = kl_pkg::MODE_WORD;
                end
                else if (kl_pkg::is_digit(c))
                begin
                    mode_next = kl_pkg::MODE_NUMBER;
                end
                else
                begin
                    mode_next = kl_pkg::MODE_IDLE;
                end
            end
        end
    end

    always_comb
    begin
        word_start_next    = word_start_reg;
        word_length_next   = word_length_reg;
        keyword_alive_next = keyword_alive_reg;
        text_position_next = text_position_reg;

        tok_a.kind    = (mode_reg == kl_pkg::MODE_WORD)
                        ? kl_pkg::word_kind(keyword_alive_reg, word_length_reg)
                        : kl_pkg::KIND_INTEGER;
        tok_a.start   = word_start_reg;
        tok_a.length  = word_length_reg;
        tok_a.tbyte   = 8'h00;
        tok_a.is_last = 1'b0;

        tok_b.kind    = kl_pkg::op_kind(c);
        tok_b.start   = pos16;
        tok_b.length  = 16'd1;
        tok_b.tbyte   = c;
        tok_b.is_last = 1'b1;

        has_a = 1'b0;
        has_b = 1'b0;

        if (accept)
        begin
            text_position_next = text_position_reg + {{(POSITION_BITS-1){1'b0}}, 1'b1};
            if (eot)
            begin
                has_a = pending;
                has_b = 1'b1;
                tok_b.kind   = kl_pkg::KIND_END;
                tok_b.length = 16'd0;
                tok_b.tbyte  = 8'h00;
                word_start_next    = 16'd0;
                word_length_next   = 16'd0;
                keyword_alive_next = kl_pkg::KW_ALL;
                text_position_next = '0;
            end
            else if (cont)
            begin
                word_length_next = length_inc;
                if (mode_reg == kl_pkg::MODE_WORD)
                begin
                    keyword_alive_next = kl_pkg::kw_narrow(keyword_alive_reg, c, word_length_reg);
                end
            end
            else
            begin
                has_a = pending;
                if (kl_pkg::is_letter(c))
                begin
                    word_start_next    = pos16;
                    word_length_next   = 16'd1;
                    keyword_alive_next = kl_pkg::kw_narrow(kl_pkg::KW_ALL, c, 16'd0);
                end
                else if (kl_pkg::is_digit(c))
                begin
                    word_start_next  = pos16;
                    word_length_next = 16'd1;
                end
                else if (!kl_pkg::is_blank(c))
                begin
                    has_b = 1'b1;
                end
            end
        end

        tok_a.is_last = !has_b;
        push.cnt  = 2'(has_a) + 2'(has_b);
        push.tok0 = has_a ? tok_a : tok_b;
        push.tok1 = tok_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= kl_pkg::MODE_IDLE;
            word_start_reg    <= 16'd0;
            word_length_reg   <= 16'd0;
            text_position_reg <= '0;
            keyword_alive_reg <= kl_pkg::KW_ALL;
        end
        else
        begin
            mode_reg          <= mode_next;
            word_start_reg    <= word_start_next;
            word_length_reg   <= word_length_next;
            text_position_reg <= text_position_next;
            keyword_alive_reg <= keyword_alive_next;
        end
    end

    kl_token_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (out_tok)
    );

    assign m_axis_tdata = {3'b000, out_tok.tbyte, out_tok.length, out_tok.start, out_tok.kind};
    assign m_axis_tlast = out_tok.is_last;

endmodule

### sim/testbench.sv
module testbench;

    class token_ledger;
        kl_pkg::tok_t  pending_tokens[$];
        int unsigned   mismatches;
        string         kw_names[4];
        string         op_chars;
        kl_pkg::mode_t scan;
        logic [15:0]   tok_start;
        logic [15:0]   tok_len;
        logic [15:0]   next_pos;
        logic [3:0]    kw_live;

        function new();
            kw_names = '{"if", "for", "while", "than"};
            op_chars = "+-/*(){}&;=><";
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            scan = kl_pkg::MODE_IDLE;
            tok_start = '0;
            tok_len = '0;
            next_pos = '0;
            kw_live = kl_pkg::KW_ALL;
        endfunction

        function void narrow(logic [7:0] c, logic [15:0] idx);
            for (int k = 0; k < 4; k++)
            begin
                if (kw_live[k] && (idx >= kw_names[k].len() || kw_names[k][int'(idx)] != c))
                begin
                    kw_live[k] = 1'b0;
                end
            end
        endfunction

        function kl_pkg::kind_t pending_kind();
            if (scan == kl_pkg::MODE_NUMBER)
            begin
                return kl_pkg::KIND_INTEGER;
            end
            for (int k = 0; k < 4; k++)
            begin
                if (kw_live[k] && tok_len == kw_names[k].len())
                begin
                    return kl_pkg::kind_t'(int'(kl_pkg::KIND_IF) + k);
                end
            end
            return kl_pkg::KIND_IDENT;
        endfunction

        function void push(kl_pkg::kind_t kind, logic [15:0] start, logic [15:0] len,
                           logic [7:0] b);
            kl_pkg::tok_t t;
            t.kind = kind;
            t.start = start;
            t.length = len;
            t.tbyte = b;
            t.is_last = 1'b0;
            pending_tokens.push_back(t);
        endfunction

        function void flush();
            if (scan != kl_pkg::MODE_IDLE)
            begin
                push(pending_kind(), tok_start, tok_len, 8'h00);
            end
            scan = kl_pkg::MODE_IDLE;
        endfunction

        function void take_byte(logic [7:0] c, logic eot);
            int            first;
            logic          letter;
            logic          digit;
            kl_pkg::kind_t kind;
            first = pending_tokens.size();
            letter = c inside {["A":"Z"], ["a":"z"]};
            digit = c inside {["0":"9"]};
            if (eot)
            begin
                flush();
                push(kl_pkg::KIND_END, next_pos, 16'd0, 8'h00);
                restart();
            end
            else
            begin
                if (scan == kl_pkg::MODE_WORD && (letter || c == kl_pkg::CHAR_UNDERSCORE))
                begin
                    narrow(c, tok_len);
                    if (tok_len != kl_pkg::LEN_MAX)
                    begin
                        tok_len++;
                    end
                end
                else if (scan == kl_pkg::MODE_NUMBER && digit)
                begin
                    if (tok_len != kl_pkg::LEN_MAX)
                    begin
                        tok_len++;
                    end
                end
                else
                begin
                    flush();
                    if (letter)
                    begin
                        scan = kl_pkg::MODE_WORD;
                        tok_start = next_pos;
                        kw_live = kl_pkg::KW_ALL;
                        narrow(c, 16'd0);
                        tok_len = 16'd1;
                    end
                    else if (digit)
                    begin
                        scan = kl_pkg::MODE_NUMBER;
                        tok_start = next_pos;
                        tok_len = 16'd1;
                    end
                    else if (c != kl_pkg::CHAR_SPACE && c != kl_pkg::CHAR_NEWLINE)
                    begin
                        kind = kl_pkg::KIND_UNKNOWN;
                        for (int k = 0; k < op_chars.len(); k++)
                        begin
                            if (op_chars[k] == c && kind == kl_pkg::KIND_UNKNOWN)
                            begin
                                kind = kl_pkg::kind_t'(int'(kl_pkg::KIND_PLUS) + k);
                            end
                        end
                        push(kind, next_pos, 16'd1, c);
                    end
                end
                next_pos++;
            end
            if (pending_tokens.size() > first)
            begin
                pending_tokens[pending_tokens.size() - 1].is_last = 1'b1;
            end
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void match_token(logic [47:0] d, logic last);
            kl_pkg::tok_t want;
            if (pending_tokens.size() == 0)
            begin
                $error("token with nothing expected: tdata=%h tlast=%b", d, last);
                mismatches++;
                return;
            end
            want = pending_tokens.pop_front();
            compare("token_kind", want.kind, d[4:0]);
            compare("token_start", want.start, d[20:5]);
            compare("token_length", want.length, d[36:21]);
            compare("token_byte", want.tbyte, d[44:37]);
            compare("last_of_run", want.is_last, last);
            compare("tdata padding", 0, d[47:45]);
        endfunction
    endclass

    localparam int RANDOM_WORDS = 850;
    localparam int HOLD_CYCLES = 100;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    token_ledger sb;
    logic        quiet;
    logic        long_hold_req;
    int          words_sent;

    keyword_lexer dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] random_letter();
        return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                    : 8'("A" + $urandom_range(0, 25));
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eot);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        s_axis_tdata <= b;
        s_axis_tuser <= eot;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.take_byte(b, eot);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(s[i], 1'b0);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending_tokens.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_random_token();
        int         pick;
        int         k;
        int         n;
        int         m;
        int         j;
        logic [7:0] ch;
        pick = $urandom_range(0, 15);
        if (pick <= 2)
        begin
            send_text(sb.kw_names[$urandom_range(0, 3)]);
        end
        else if (pick == 3)
        begin
            // Near miss of a keyword: cut short, extended, one letter changed or case flipped.
            k = $urandom_range(0, 3);
            m = $urandom_range(0, 3);
            n = sb.kw_names[k].len();
            j = $urandom_range(0, n - 1);
            if (m == 0)
            begin
                n--;
            end
            for (int i = 0; i < n; i++)
            begin
                ch = sb.kw_names[k][i];
                if (m == 2 && i == j)
                begin
                    ch = random_letter();
                end
                if (m == 3)
                begin
                    ch ^= 8'h20;
                end
                send_word(ch, 1'b0);
            end
            if (m == 1)
            begin
                send_word($urandom_range(0, 1) ? kl_pkg::CHAR_UNDERSCORE : random_letter(),
                          1'b0);
            end
        end
        else if (pick <= 5)
        begin
            n = $urandom_range(1, 8);
            send_word(random_letter(), 1'b0);
            for (int i = 1; i < n; i++)
            begin
                send_word(($urandom_range(0, 4) == 0) ? kl_pkg::CHAR_UNDERSCORE : random_letter(),
                          1'b0);
            end
        end
        else if (pick <= 7)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
        end
        else if (pick <= 10)
        begin
            send_word(sb.op_chars[$urandom_range(0, 12)], 1'b0);
        end
        else if (pick == 11 || pick == 14)
        begin
            send_word($urandom_range(0, 1) ? kl_pkg::CHAR_SPACE : kl_pkg::CHAR_NEWLINE, 1'b0);
        end
        else if (pick == 12)
        begin
            send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (pick == 13)
        begin
            send_word(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            send_word(kl_pkg::CHAR_UNDERSCORE, 1'b0);
        end
    endtask

    initial
    begin
        int stalls_left;
        m_axis_tready = 1'b0;
        stalls_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                sb.match_token(m_axis_tdata, m_axis_tlast);
            end
            if (long_hold_req)
            begin
                stalls_left = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            @(negedge clk);
            if (stalls_left == 0 && !quiet && $urandom_range(0, 3) == 0)
            begin
                stalls_left = pick_gap();
            end
            if (stalls_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stalls_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic held;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = 1'b0;
        rst_n = 1'b0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        words_sent = 0;
        held = 1'b0;
        sb = new();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(8'hFF, 1'b1);
        send_word(kl_pkg::CHAR_UNDERSCORE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_text("while;if9x\n+-/*(){}&=><");
        send_word(8'h00, 1'b1);
        drain();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (!held && words_sent >= 300)
            begin
                held = 1'b1;
                quiet = 1'b1;
                long_hold_req = 1'b1;
                repeat (30) send_word("+", 1'b0);
                quiet = 1'b0;
            end
            if (words_sent >= 600 && words_sent < 610)
            begin
                drain();
                words_sent = 610;
            end
            send_random_token();
        end
        drain();
        repeat (20) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending_tokens.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

### files.f
hdl/kl_pkg.sv
hdl/kl_token_fifo.sv
hdl/keyword_lexer.sv
sim/testbench.sv
